// ===== rtl/sqvs_pkg.sv =====
package sqvs_pkg;

    localparam int COORD_W     = 24;
    localparam int UV_W        = 18;
    localparam int SIN_W       = 15;
    localparam int PIPE_STAGES = 7;
    localparam int XF_STAGES   = 5;
    localparam int DIV_STEPS   = 3;
    localparam int DIV_SWEEPS  = 6;

    localparam logic [1:0] CORNER_LAST = 2'd3;
    localparam logic [UV_W-1:0] UV_MAX = 18'h3FFFF;
    localparam logic [UV_W-1:0] UV_ONE = 18'h10000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [15:0]        rot;
        logic [15:0]        tw;
        logic [15:0]        th;
        logic [15:0]        minx;
        logic [15:0]        miny;
        logic [15:0]        maxx;
        logic [15:0]        maxy;
        logic [31:0]        tint;
    } sprite_t;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [15:0]        rot;
        logic [15:0]        tw;
        logic [15:0]        th;
        logic [15:0]        u_texel;
        logic [15:0]        v_texel;
        logic               uv_dflt;
        logic               u_one;
        logic               v_one;
        logic [31:0]        abgr;
        logic [1:0]         corner;
    } corner_word_t;

    // quarter-wave sine in Q1.14, Taylor series in Q30
    function automatic logic [SIN_W-1:0] quarter_sine(input longint unsigned r,
                                                      input int unsigned b);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (r * HALF_PI_Q30) >> (b - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0) sum = 0;
        sum = (sum + 32768) >>> 16;
        if (sum > 16384) sum = 16384;
        return SIN_W'(sum);
    endfunction

endpackage

// ===== rtl/sqvs_corner_gen.sv =====
module sqvs_corner_gen import sqvs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         in_tex_ready,
    input  sprite_t      in_sprite,
    input  logic         advance,
    output logic         out_valid,
    output corner_word_t out_word
);

    logic    busy_reg;
    logic [1:0] cnt_reg;
    sprite_t spr_reg;
    logic    take;
    logic    uv_ok;
    logic    cx;
    logic    cy;

    assign in_ready  = !busy_reg || (cnt_reg == CORNER_LAST && advance);
    assign take      = in_valid && in_ready;
    assign out_valid = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else if (take) begin
            busy_reg <= in_tex_ready;
            cnt_reg  <= 2'd0;
        end else if (busy_reg && advance) begin
            if (cnt_reg == CORNER_LAST) busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) spr_reg <= in_sprite;
    end

    assign uv_ok = (spr_reg.tw != 16'd0) && (spr_reg.th != 16'd0) &&
                   (spr_reg.maxx > spr_reg.minx) && (spr_reg.maxy > spr_reg.miny);
    assign cx = (cnt_reg == 2'd1) || (cnt_reg == 2'd2);
    assign cy = cnt_reg[1];

    always_comb begin
        out_word.px      = spr_reg.px;
        out_word.py      = spr_reg.py;
        out_word.ox      = spr_reg.ox;
        out_word.oy      = spr_reg.oy;
        out_word.sx      = spr_reg.sx;
        out_word.sy      = spr_reg.sy;
        out_word.rot     = spr_reg.rot;
        out_word.tw      = spr_reg.tw;
        out_word.th      = spr_reg.th;
        out_word.u_texel = cx ? spr_reg.maxx : spr_reg.minx;
        out_word.v_texel = cy ? spr_reg.maxy : spr_reg.miny;
        out_word.uv_dflt = !uv_ok;
        out_word.u_one   = cx;
        out_word.v_one   = cy;
        out_word.abgr    = {spr_reg.tint[7:0], spr_reg.tint[15:8],
                            spr_reg.tint[23:16], spr_reg.tint[31:24]};
        out_word.corner  = cnt_reg;
    end

endmodule

// ===== rtl/sqvs_uv_div.sv =====
module sqvs_uv_div import sqvs_pkg::*; (
    input  logic            aclk,
    input  logic            en,
    input  logic [15:0]     texel,
    input  logic [15:0]     size,
    input  logic            dflt,
    input  logic            one,
    output logic [UV_W-1:0] quot
);

    typedef struct packed {
        logic [15:0]     rem;
        logic [17:0]     nlo;
        logic [UV_W-1:0] q;
        logic [15:0]     d;
        logic            sat;
        logic            dflt;
        logic            one;
    } div_st_t;

    function automatic div_st_t div_step(input div_st_t a);
        div_st_t    o;
        logic [16:0] t;
        o   = a;
        t   = {a.rem, a.nlo[17]};
        o.nlo = {a.nlo[16:0], 1'b0};
        if (t >= {1'b0, a.d}) begin
            o.rem = 16'(t - {1'b0, a.d});
            o.q   = {a.q[UV_W-2:0], 1'b1};
        end else begin
            o.rem = t[15:0];
            o.q   = {a.q[UV_W-2:0], 1'b0};
        end
        return o;
    endfunction

    div_st_t     st_reg [DIV_SWEEPS+1];
    div_st_t     prep_next;
    logic [31:0] num;

    always_comb begin
        num = {texel, 16'd0} + {17'd0, size[15:1]};
        prep_next.rem  = {2'd0, num[31:18]};
        prep_next.nlo  = num[17:0];
        prep_next.q    = '0;
        prep_next.d    = size;
        prep_next.sat  = {2'd0, num} >= {size, 18'd0};
        prep_next.dflt = dflt;
        prep_next.one  = one;
    end

    always_ff @(posedge aclk) begin
        if (en) st_reg[0] <= prep_next;
    end

    for (genvar g = 1; g <= DIV_SWEEPS; g++) begin : g_sweep
        div_st_t sw_next;
        always_comb begin
            sw_next = st_reg[g-1];
            for (int i = 0; i < DIV_STEPS; i++) sw_next = div_step(sw_next);
        end
        always_ff @(posedge aclk) begin
            if (en) st_reg[g] <= sw_next;
        end
    end

    assign quot = st_reg[DIV_SWEEPS].dflt ? (st_reg[DIV_SWEEPS].one ? UV_ONE : '0) :
                  st_reg[DIV_SWEEPS].sat  ? UV_MAX : st_reg[DIV_SWEEPS].q;

endmodule

// ===== rtl/sqvs_xform.sv =====
module sqvs_xform import sqvs_pkg::*; #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                      aclk,
    input  logic                      en,
    input  corner_word_t              w,
    output logic signed [COORD_W-1:0] vx,
    output logic signed [COORD_W-1:0] vy
);

    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int IW      = SINE_TABLE_BITS - 1;

    logic [SIN_W-1:0] sin_tab [QUARTER+1];
    for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
        assign sin_tab[g] = quarter_sine(longint'(g), SINE_TABLE_BITS);
    end

    function automatic logic signed [15:0] sine_at(input logic [SINE_TABLE_BITS-1:0] k,
                                                   input logic [SIN_W-1:0] tab [QUARTER+1]);
        logic [IW-1:0]    idx;
        logic [SIN_W-1:0] mag;
        if (k[SINE_TABLE_BITS-2])
            idx = IW'(QUARTER) - {1'b0, k[SINE_TABLE_BITS-3:0]};
        else
            idx = {1'b0, k[SINE_TABLE_BITS-3:0]};
        mag = tab[idx];
        return k[SINE_TABLE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    logic [SINE_TABLE_BITS-1:0] k;
    logic [SINE_TABLE_BITS-1:0] kc;
    assign k  = w.rot[15 -: SINE_TABLE_BITS];
    assign kc = k + SINE_TABLE_BITS'(QUARTER);

    // stage 1: products and lookup
    logic signed [32:0] pw_reg, ph_reg;
    logic signed [39:0] oxs_reg, oys_reg;
    logic signed [15:0] s1_reg, c1_reg, s2_reg, c2_reg, s3_reg, c3_reg;
    logic signed [23:0] px1_reg, py1_reg, px2_reg, py2_reg, px3_reg, py3_reg;
    logic               cx1_reg, cy1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pw_reg  <= 33'($signed({1'b0, w.tw})) * 33'(w.sx);
            ph_reg  <= 33'($signed({1'b0, w.th})) * 33'(w.sy);
            oxs_reg <= 40'(w.ox) * 40'(w.sx);
            oys_reg <= 40'(w.oy) * 40'(w.sy);
            s1_reg  <= sine_at(k, sin_tab);
            c1_reg  <= sine_at(kc, sin_tab);
            px1_reg <= w.px;
            py1_reg <= w.py;
            cx1_reg <= (w.corner == 2'd1) || (w.corner == 2'd2);
            cy1_reg <= w.corner[1];
        end
    end

    // stage 2: local corner minus scaled origin
    logic signed [40:0] lx, ly;
    logic signed [41:0] rx_reg, ry_reg;
    assign lx = cx1_reg ? (41'(pw_reg) <<< 7) : -(41'(pw_reg) <<< 7);
    assign ly = cy1_reg ? (41'(ph_reg) <<< 7) : -(41'(ph_reg) <<< 7);

    always_ff @(posedge aclk) begin
        if (en) begin
            rx_reg  <= 42'(lx) - 42'(oxs_reg);
            ry_reg  <= 42'(ly) - 42'(oys_reg);
            s2_reg  <= s1_reg;
            c2_reg  <= c1_reg;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
        end
    end

    // stage 3: rotation products
    logic signed [57:0] xa_reg, xb_reg, ya_reg, yb_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg  <= 58'(rx_reg) * 58'(c2_reg);
            xb_reg  <= 58'(ry_reg) * 58'(s2_reg);
            ya_reg  <= 58'(rx_reg) * 58'(s2_reg);
            yb_reg  <= 58'(ry_reg) * 58'(c2_reg);
            px3_reg <= px2_reg;
            py3_reg <= py2_reg;
        end
    end

    // stage 4: round to Q.8 and translate
    logic signed [58:0] xsum, ysum;
    logic signed [37:0] wx_reg, wy_reg;
    assign xsum = 59'(xa_reg) - 59'(xb_reg) + 59'(64'sd2097152);
    assign ysum = 59'(ya_reg) + 59'(yb_reg) + 59'(64'sd2097152);

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg <= 38'(xsum >>> 22) + 38'(px3_reg);
            wy_reg <= 38'(ysum >>> 22) + 38'(py3_reg);
        end
    end

    // stage 5: saturate
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [37:0] v);
        if (v > 38'(COORD_MAX)) return COORD_MAX;
        if (v < 38'(COORD_MIN)) return COORD_MIN;
        return COORD_W'(v);
    endfunction

    logic signed [COORD_W-1:0] vx_reg, vy_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg <= sat_coord(wx_reg);
            vy_reg <= sat_coord(wy_reg);
        end
    end

    assign vx = vx_reg;
    assign vy = vy_reg;

endmodule

// ===== rtl/sprite_quad_vertex_setup_core.sv =====
// channel | dir | tdata                                        | tuser         | tlast
// s_      | in  | position, origin, scale, rotation, size,      | texture_ready | -
//         |     | rect_min, rect_max, tint (272 bits)          |               |
// m_      | out | vertex_x, vertex_y, tex_u, tex_v, color_abgr | corner        | last
// One sprite gives four corner words, one per cycle unless m_ stalls, set by the
// corner sequencer. From sprite accept to first corner word: sequencer register,
// then 7 pipeline stages (UV divider of 6 sweeps of 3 quotient bits).
// Sprites without a ready texture are accepted and give no word.
// A stall on m_ holds the whole pipeline; nothing is lost or repeated.
// Reset is synchronous, active low, and clears valid state and the corner count only.
module sprite_quad_vertex_setup_core import sqvs_pkg::*; #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // position[47:0], origin[95:48], scale[127:96], rotation[143:128],
    // texture_size[175:144], rect_min[207:176], rect_max[239:208], tint[271:240]
    input  logic [271:0] s_tdata,
    // texture_ready[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertex_x[23:0], vertex_y[47:24], tex_u[65:48], tex_v[83:66],
    // color_abgr[115:84], zero[119:116]
    output logic [119:0] m_tdata,
    // corner[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    sprite_t      spr;
    corner_word_t cw;
    logic         cw_valid;
    logic         en;
    logic [PIPE_STAGES-1:0] vld_reg;

    assign en = !vld_reg[PIPE_STAGES-1] || m_tready;

    always_comb begin
        spr.px   = s_tdata[23:0];
        spr.py   = s_tdata[47:24];
        spr.ox   = s_tdata[71:48];
        spr.oy   = s_tdata[95:72];
        spr.sx   = s_tdata[111:96];
        spr.sy   = s_tdata[127:112];
        spr.rot  = s_tdata[143:128];
        spr.tw   = s_tdata[159:144];
        spr.th   = s_tdata[175:160];
        spr.minx = s_tdata[191:176];
        spr.miny = s_tdata[207:192];
        spr.maxx = s_tdata[223:208];
        spr.maxy = s_tdata[239:224];
        spr.tint = s_tdata[271:240];
    end

    sqvs_corner_gen u_gen (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_tex_ready (s_tuser[0]),
        .in_sprite    (spr),
        .advance      (en),
        .out_valid    (cw_valid),
        .out_word     (cw)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], cw_valid};
        end
    end

    logic signed [COORD_W-1:0] vx, vy;
    sqvs_xform #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_xform (
        .aclk (aclk),
        .en   (en),
        .w    (cw),
        .vx   (vx),
        .vy   (vy)
    );

    logic [UV_W-1:0] tex_u, tex_v;
    sqvs_uv_div u_div_u (
        .aclk  (aclk),
        .en    (en),
        .texel (cw.u_texel),
        .size  (cw.tw),
        .dflt  (cw.uv_dflt),
        .one   (cw.u_one),
        .quot  (tex_u)
    );

    sqvs_uv_div u_div_v (
        .aclk  (aclk),
        .en    (en),
        .texel (cw.v_texel),
        .size  (cw.th),
        .dflt  (cw.uv_dflt),
        .one   (cw.v_one),
        .quot  (tex_v)
    );

    // align vertex results with the divider
    localparam int XD = PIPE_STAGES - XF_STAGES;
    logic signed [COORD_W-1:0] vx_reg [XD];
    logic signed [COORD_W-1:0] vy_reg [XD];
    logic [31:0] abgr_reg   [PIPE_STAGES];
    logic [1:0]  corner_reg [PIPE_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg[0]     <= vx;
            vy_reg[0]     <= vy;
            abgr_reg[0]   <= cw.abgr;
            corner_reg[0] <= cw.corner;
            for (int i = 1; i < XD; i++) begin
                vx_reg[i] <= vx_reg[i-1];
                vy_reg[i] <= vy_reg[i-1];
            end
            for (int i = 1; i < PIPE_STAGES; i++) begin
                abgr_reg[i]   <= abgr_reg[i-1];
                corner_reg[i] <= corner_reg[i-1];
            end
        end
    end

    assign m_tvalid = vld_reg[PIPE_STAGES-1];
    assign m_tdata  = {4'd0, abgr_reg[PIPE_STAGES-1], tex_v, tex_u,
                       vy_reg[XD-1], vx_reg[XD-1]};
    assign m_tuser  = corner_reg[PIPE_STAGES-1];
    assign m_tlast  = (corner_reg[PIPE_STAGES-1] == CORNER_LAST);

endmodule

// ===== rtl/sqvs_checker.sv =====
module sqvs_checker import sqvs_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed under stall");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == CORNER_LAST)))
        else $error("last flag does not match corner");

    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |->
            (m_tuser == 2'($past(m_tuser) + 2'd1)))
        else $error("corner order broken");

    a_color: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |->
            (m_tdata[115:84] == $past(m_tdata[115:84])))
        else $error("color changed inside a sprite");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind sprite_quad_vertex_setup_core sqvs_checker u_sqvs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/sprite_quad_vertex_setup_core_tb.sv =====
`timescale 1ns / 1ps

module sprite_quad_vertex_setup_core_tb;
    import sqvs_pkg::*;

    localparam int TABLE_BITS = 10;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic [23:0] vx;
        logic [23:0] vy;
        logic [17:0] u;
        logic [17:0] v;
        logic [31:0] abgr;
        logic [1:0]  corner;
        logic        last;
    } vertex_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [271:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    vertex_t expected_vertices[$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      hold_off = 0;
    longint  cycles = 0;

    always #1 aclk = ~aclk;

    sprite_quad_vertex_setup_core #(.SINE_TABLE_BITS(TABLE_BITS)) DUT (.*);

    function automatic longint quarter_wave(longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x = (r * 64'd1686629713) >> (TABLE_BITS - 2);
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        acc = (acc + 32768) >>> 16;
        if (acc > 16384) acc = 16384;
        return acc;
    endfunction

    function automatic longint sine_of(longint unsigned k);
        longint unsigned q;
        longint unsigned r;
        longint          sv;
        k = k & ((64'd1 << TABLE_BITS) - 1);
        q = k >> (TABLE_BITS - 2);
        r = k & ((64'd1 << (TABLE_BITS - 2)) - 1);
        sv = q[0] ? quarter_wave((64'd1 << (TABLE_BITS - 2)) - r) : quarter_wave(r);
        return q[1] ? -sv : sv;
    endfunction

    function automatic logic [23:0] clamp_coord(longint val);
        if (val > 8388607) val = 8388607;
        if (val < -8388608) val = -8388608;
        return val[23:0];
    endfunction

    function automatic logic [17:0] uv_ratio(longint texel, longint size);
        longint q;
        q = ((texel << 16) + (size >> 1)) / size;
        return (q > 262143) ? 18'h3FFFF : q[17:0];
    endfunction

    function automatic longint round_q8(longint val);
        return val >>> 22;
    endfunction

    task automatic predict_corners(logic ready, logic [271:0] d);
        longint px, py, ox, oy, sx, sy, tw, th, mnx, mny, mxx, mxy;
        longint hw, hh, oxs, oys, sn, cs, lx, ly, rx, ry;
        logic [17:0] u0, v0, u1, v1;
        logic [31:0] t;
        longint unsigned k;
        vertex_t e;
        if (!ready) return;
        px = longint'($signed(d[23:0]));
        py = longint'($signed(d[47:24]));
        ox = longint'($signed(d[71:48]));
        oy = longint'($signed(d[95:72]));
        sx = longint'($signed(d[111:96]));
        sy = longint'($signed(d[127:112]));
        tw = longint'(d[159:144]);
        th = longint'(d[175:160]);
        mnx = longint'(d[191:176]);
        mny = longint'(d[207:192]);
        mxx = longint'(d[223:208]);
        mxy = longint'(d[239:224]);
        t = d[271:240];
        u0 = '0; v0 = '0; u1 = 18'h10000; v1 = 18'h10000;
        if (tw > 0 && th > 0 && mxx > mnx && mxy > mny) begin
            u0 = uv_ratio(mnx, tw);
            v0 = uv_ratio(mny, th);
            u1 = uv_ratio(mxx, tw);
            v1 = uv_ratio(mxy, th);
        end
        hw = tw * sx * 128;
        hh = th * sy * 128;
        oxs = ox * sx;
        oys = oy * sy;
        k = longint'(d[143:128]) >> (16 - TABLE_BITS);
        sn = sine_of(k);
        cs = sine_of(k + (64'd1 << (TABLE_BITS - 2)));
        for (int i = 0; i < 4; i++) begin
            lx = (i == 1 || i == 2) ? hw : -hw;
            ly = (i >= 2) ? hh : -hh;
            rx = lx - oxs;
            ry = ly - oys;
            e.vx = clamp_coord(round_q8(rx * cs - ry * sn + (64'd1 << 21)) + px);
            e.vy = clamp_coord(round_q8(rx * sn + ry * cs + (64'd1 << 21)) + py);
            e.u = (i == 1 || i == 2) ? u1 : u0;
            e.v = (i >= 2) ? v1 : v0;
            e.abgr = {t[7:0], t[15:8], t[23:16], t[31:24]};
            e.corner = i[1:0];
            e.last = (i == 3);
            expected_vertices.push_back(e);
        end
    endtask

    task automatic send_sprite(logic ready, logic [271:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= ready;
        predict_corners(ready, d);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [271:0] make_sprite(logic [23:0] px, logic [23:0] py,
            logic [23:0] ox, logic [23:0] oy, logic [15:0] sx, logic [15:0] sy,
            logic [15:0] rot, logic [15:0] tw, logic [15:0] th, logic [31:0] rmin,
            logic [31:0] rmax, logic [31:0] tint);
        return {tint, rmax, rmin, th, tw, rot, sy, sx, oy, ox, py, px};
    endfunction

    function automatic logic [271:0] random_sprite();
        logic [271:0] d;
        logic [15:0]  tw, th;
        d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
        if ($urandom_range(3) != 0) begin
            tw = 16'($urandom_range(1, 512));
            th = 16'($urandom_range(1, 512));
            d[175:144] = {th, tw};
            d[191:176] = 16'($urandom_range(0, tw));
            d[207:192] = 16'($urandom_range(0, th));
            d[223:208] = 16'($urandom_range(0, 2 * tw));
            d[239:224] = 16'($urandom_range(0, 2 * th));
            d[111:96] = 16'($signed($urandom_range(0, 1024)) - 512);
            d[127:112] = 16'($signed($urandom_range(0, 1024)) - 512);
            d[71:48] = 24'($signed($urandom_range(0, 8192)) - 4096);
            d[95:72] = 24'($signed($urandom_range(0, 8192)) - 4096);
        end
        return d;
    endfunction

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_sprite(1, make_sprite(0, 0, 0, 0, 16'h0100, 16'h0100, 0, 16, 16,
            {16'd0, 16'd0}, {16'd16, 16'd16}, 32'h11223344));
        send_sprite(1, make_sprite(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
            16'h7FFF, 16'h8000, 16'h4000, 16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFFFFFF,
            32'hFFFFFFFF));
        send_sprite(1, make_sprite(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
            16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0001, 32'hFFFFFFFF, 32'h0,
            32'h0));
        send_sprite(0, make_sprite(1, 2, 3, 4, 16'h0100, 16'h0100, 0, 8, 8, 0,
            {16'd8, 16'd8}, 32'hDEADBEEF));
        send_sprite(1, make_sprite(0, 0, 0, 0, 16'h0100, 16'h0100, 16'h2000, 0, 32,
            0, {16'd8, 16'd8}, 32'hA5A5A5A5));
        send_sprite(1, make_sprite(0, 0, 0, 0, 16'h0100, 16'h0100, 16'h8000, 32, 0,
            0, {16'd8, 16'd8}, 32'h5A5A5A5A));
        send_sprite(1, make_sprite(100, 200, 0, 0, 16'h0100, 16'h0100, 16'hC000, 32,
            32, {16'd8, 16'd8}, {16'd8, 16'd4}, 32'h01020304));
        send_sprite(1, make_sprite(100, 200, 0, 0, 16'hFF00, 16'hFE00, 16'h6000, 32,
            32, {16'd8, 16'd8}, {16'd4, 16'd16}, 32'h01020304));
        send_sprite(1, make_sprite(0, 0, 24'h000080, 24'h000080, 16'h0080, 16'h0200,
            16'h1234, 3, 7, {16'd1, 16'd1}, {16'd20, 16'd30}, 32'hFF00FF00));
        send_sprite(1, make_sprite(0, 0, 0, 0, 16'h0100, 16'h0100, 16'h003F, 1, 1,
            {16'd65535, 16'd65534}, {16'd65535, 16'd65535}, 32'h0));
        send_sprite(1, make_sprite(0, 0, 0, 0, 16'h0100, 16'h0100, 16'h0040, 3, 3,
            {16'd0, 16'd0}, {16'd65535, 16'd65535}, 32'h0));
        wait_drain();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++) send_sprite($urandom_range(7) != 0, random_sprite());
        wait_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 150;
        for (int i = 0; i < 12; i++) send_sprite(1, random_sprite());
        wait_drain();
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("sprite_quad_vertex_setup_core_tb: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        vertex_t e;
        vertex_t a;
        if (aresetn && m_tvalid && m_tready) begin
            a.vx = m_tdata[23:0];
            a.vy = m_tdata[47:24];
            a.u = m_tdata[65:48];
            a.v = m_tdata[83:66];
            a.abgr = m_tdata[115:84];
            a.corner = m_tuser;
            a.last = m_tlast;
            if (expected_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %p", a);
            end else begin
                e = expected_vertices.pop_front();
                if (a != e) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: exp %p got %p", e, a);
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(25, 0, 0);
        test_random(25, 56, 0);
        test_random(25, 0, 56);
        test_random(25, 8, 8);
        test_backpressure();
        if (mismatches == 0) begin
            $display("sprite_quad_vertex_setup_core_tb: done, clean");
        end else begin
            $display("sprite_quad_vertex_setup_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sprite_quad_vertex_setup_core.f =====
rtl/sqvs_pkg.sv
rtl/sqvs_corner_gen.sv
rtl/sqvs_uv_div.sv
rtl/sqvs_xform.sv
rtl/sprite_quad_vertex_setup_core.sv
rtl/sqvs_checker.sv
tb/sv/sprite_quad_vertex_setup_core_tb.sv
